### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset
`define CTHV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define CTHV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CTHV_ASSERT(lbl, prop, msg)
`define CTHV_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### src/cthv_pkg.sv
// ----------------------------------------------------------------------------
// cthv_pkg
// Types, constants and character classes of the Content-Type line checker.
// ----------------------------------------------------------------------------
package cthv_pkg;

  localparam int unsigned QueueDepthDef = 2;
  localparam logic [3:0]  NameLen       = 4'd12;

  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChSlash   = 8'h2F;
  localparam logic [7:0] ChSemi    = 8'h3B;
  localparam logic [7:0] ChEquals  = 8'h3D;
  localparam logic [7:0] ChQuote   = 8'h22;
  localparam logic [7:0] ChDel     = 8'h7F;

  typedef enum logic [3:0] {
    PH_NAME  = 4'd0,
    PH_LEAD  = 4'd1,
    PH_TYPE  = 4'd2,
    PH_SUB   = 4'd3,
    PH_KEY   = 4'd4,
    PH_VALUE = 4'd5,
    PH_TRAIL = 4'd6
  } phase_e;

  // classified item handed from front to back
  typedef struct packed {
    logic [7:0] line_byte;
    logic       eol;
    logic       tok;
    logic       blank;
    logic       bad_in_quote;
    logic       colon;
    logic       slash;
    logic       semi;
    logic       equals;
    logic       quote;
    logic       newline;
  } item_t;

  function automatic logic [7:0] name_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h43; // C
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h54; // T
      4'd9:    ch = 8'h79; // y
      4'd10:   ch = 8'h70; // p
      4'd11:   ch = 8'h65; // e
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_ctl(input logic [7:0] ch);
    return (ch < 8'd32) || (ch == ChDel);
  endfunction

  function automatic logic is_token(input logic [7:0] ch);
    logic sep;
    unique case (ch)
      8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
      8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: sep = 1'b1;
      default: sep = 1'b0;
    endcase
    return !sep && !is_ctl(ch);
  endfunction

endpackage

### src/cthv_front.sv
// ----------------------------------------------------------------------------
// cthv_front
// Accepts line bytes and tags each with its character classes.
// ----------------------------------------------------------------------------
module cthv_front (
  input  logic               in_valid_i,
  input  logic               queue_full_i,
  input  logic [7:0]         line_byte_i,
  input  logic               end_of_line_i,
  output logic               push_o,
  output cthv_pkg::item_t    item_o
);
  import cthv_pkg::*;

  assign push_o = in_valid_i && !queue_full_i;

  always_comb begin
    item_o.line_byte    = line_byte_i;
    item_o.eol          = end_of_line_i;
    item_o.tok          = is_token(line_byte_i);
    item_o.blank        = (line_byte_i == ChSpace) || (line_byte_i == ChTab);
    item_o.bad_in_quote = is_ctl(line_byte_i) && (line_byte_i != ChTab) &&
                          (line_byte_i != ChNewline);
    item_o.colon        = (line_byte_i == ChColon);
    item_o.slash        = (line_byte_i == ChSlash);
    item_o.semi         = (line_byte_i == ChSemi);
    item_o.equals       = (line_byte_i == ChEquals);
    item_o.quote        = (line_byte_i == ChQuote);
    item_o.newline      = (line_byte_i == ChNewline);
  end

endmodule

### src/cthv_queue.sv
// ----------------------------------------------------------------------------
// cthv_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cthv_queue #(
  parameter int unsigned Depth = cthv_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cthv_pkg::item_t item_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output cthv_pkg::item_t item_o
);
  import cthv_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `CTHV_ASSERT(a_count_bound, count_q <= FullCnt, "queue count over depth")
  `CTHV_ASSERT(a_no_pop_empty, pop_i |-> valid_o, "pop from empty queue")
  `CTHV_ASSERT(a_no_push_full, (full_o && !pop_i) |-> !push_i, "push into full queue")

endmodule

### src/cthv_back.sv
// ----------------------------------------------------------------------------
// cthv_back
// Grammar state machine and registered verdict output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cthv_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            item_valid_i,
  input  cthv_pkg::item_t item_i,
  output logic            item_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            accepted_o
);
  import cthv_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] name_pos_q, name_pos_d;
  logic       nonempty_q, nonempty_d;
  logic       quoted_q, quoted_d;
  logic       closed_q, closed_d;
  logic       failed_q, failed_d;
  logic       out_valid_q, out_valid_d;
  logic       accepted_q;
  logic       complete;

  // an end-of-line item needs the output register free
  assign item_pop_o = item_valid_i && (!item_i.eol || !out_valid_q || !out_stall_i);

  // line_complete on current state
  always_comb begin
    complete = 1'b0;
    unique case (phase_q)
      PH_SUB:   complete = nonempty_q;
      PH_VALUE: complete = nonempty_q && (!quoted_q || closed_q);
      PH_TRAIL: complete = 1'b1;
      default:  complete = 1'b0;
    endcase
    complete = complete && !failed_q;
  end

  // next state
  always_comb begin
    phase_d    = phase_q;
    name_pos_d = name_pos_q;
    nonempty_d = nonempty_q;
    quoted_d   = quoted_q;
    closed_d   = closed_q;
    failed_d   = failed_q;
    if (item_pop_o) begin
      if (item_i.eol) begin
        phase_d    = PH_NAME;
        name_pos_d = '0;
        nonempty_d = 1'b0;
        quoted_d   = 1'b0;
        closed_d   = 1'b0;
        failed_d   = 1'b0;
      end else if (!failed_q) begin
        unique case (phase_q)
          PH_NAME: begin
            if (name_pos_q < NameLen) begin
              if (item_i.line_byte == name_char(name_pos_q)) begin
                name_pos_d = name_pos_q + 1'b1;
              end else begin
                failed_d = 1'b1;
              end
            end else if (item_i.colon) begin
              phase_d    = PH_LEAD;
              nonempty_d = 1'b0;
            end else begin
              failed_d = 1'b1;
            end
          end
          PH_LEAD, PH_TYPE: begin
            if (phase_q == PH_LEAD && item_i.blank) begin
              phase_d = PH_LEAD;
            end else if (item_i.tok) begin
              phase_d    = PH_TYPE;
              nonempty_d = 1'b1;
            end else if (item_i.slash && nonempty_q) begin
              phase_d    = PH_SUB;
              nonempty_d = 1'b0;
            end else begin
              failed_d = 1'b1;
            end
          end
          PH_SUB: begin
            if (item_i.tok) begin
              nonempty_d = 1'b1;
            end else if (item_i.semi && nonempty_q) begin
              phase_d    = PH_KEY;
              nonempty_d = 1'b0;
            end else if (item_i.blank && nonempty_q) begin
              phase_d = PH_TRAIL;
            end else begin
              failed_d = 1'b1;
            end
          end
          PH_KEY: begin
            if (item_i.tok) begin
              nonempty_d = 1'b1;
            end else if (item_i.equals && nonempty_q) begin
              phase_d    = PH_VALUE;
              nonempty_d = 1'b0;
              quoted_d   = 1'b0;
              closed_d   = 1'b0;
            end else begin
              failed_d = 1'b1;
            end
          end
          PH_VALUE: begin
            if (!nonempty_q) begin
              if (item_i.quote) begin
                quoted_d   = 1'b1;
                nonempty_d = 1'b1;
              end else if (item_i.tok) begin
                nonempty_d = 1'b1;
              end else begin
                failed_d = 1'b1;
              end
            end else if (quoted_q && !closed_q) begin
              if (item_i.quote) begin
                closed_d = 1'b1;
              end else if (item_i.semi || item_i.bad_in_quote) begin
                failed_d = 1'b1;
              end
            end else if (item_i.tok && !quoted_q) begin
              nonempty_d = 1'b1;
            end else if (item_i.semi) begin
              phase_d    = PH_KEY;
              nonempty_d = 1'b0;
              quoted_d   = 1'b0;
              closed_d   = 1'b0;
            end else if (item_i.blank) begin
              phase_d = PH_TRAIL;
            end else begin
              failed_d = 1'b1;
            end
          end
          PH_TRAIL: begin
            if (!item_i.blank) begin
              failed_d = 1'b1;
            end
          end
          default: failed_d = 1'b1;
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (item_pop_o && item_i.eol) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_NAME;
      name_pos_q  <= '0;
      nonempty_q  <= 1'b0;
      quoted_q    <= 1'b0;
      closed_q    <= 1'b0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      name_pos_q  <= name_pos_d;
      nonempty_q  <= nonempty_d;
      quoted_q    <= quoted_d;
      closed_q    <= closed_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o && item_i.eol) begin
      accepted_q <= item_i.newline && complete;
    end
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = accepted_q;

  `CTHV_ASSERT(a_eol_gives_result, (item_pop_o && item_i.eol) |=> out_valid_q,
               "end of line without verdict")
  `CTHV_ASSERT(a_name_done, (phase_q != PH_NAME) |-> (name_pos_q == NameLen),
               "left name phase before full name")
  `CTHV_ASSERT(a_fail_sticky, (failed_q && !(item_pop_o && item_i.eol)) |=> failed_q,
               "failed line recovered before end of line")
  `CTHV_ASSERT(a_name_bound, name_pos_q <= NameLen, "name position out of range")

endmodule

### src/content_type_header_validator.sv
// ----------------------------------------------------------------------------
// content_type_header_validator
// Checks one Content-Type header line per end mark, one byte per item.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_stall_o  line_byte_i, end_of_line_i
//  out      output     out_valid_o / out_stall_i  accepted_o
//
//  One byte per cycle sustained while the queue is not full; the grammar state machine
//  takes one item a cycle unless an end-of-line item waits on a stalled verdict.
//  Reset returns the grammar to the header name phase and empties the queue.
//  A stalled verdict holds only end-of-line items; bytes behind a held one wait in the queue.
// ----------------------------------------------------------------------------
module content_type_header_validator #(
  parameter int unsigned QueueDepth = cthv_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] line_byte_i,
  input  logic       end_of_line_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       accepted_o
);
  import cthv_pkg::*;

  item_t fe_item;
  item_t be_item;
  logic  push;
  logic  pop;
  logic  full;
  logic  be_valid;

  assign in_stall_o = full;

  cthv_front u_front (
    .in_valid_i    (in_valid_i),
    .queue_full_i  (full),
    .line_byte_i   (line_byte_i),
    .end_of_line_i (end_of_line_i),
    .push_o        (push),
    .item_o        (fe_item)
  );

  cthv_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fe_item),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (be_valid),
    .item_o  (be_item)
  );

  cthv_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (be_valid),
    .item_i       (be_item),
    .item_pop_o   (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .accepted_o   (accepted_o)
  );

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Feeds Content-Type header lines to content_type_header_validator one byte
// per item, with bursty input and a receiver that stalls in shifting patterns.
// A grammar tracker in the bench predicts the verdict of every line, and the
// monitor compares each verdict that leaves the block against the oldest one
// predicted. Directed lines come first, then random lines: mostly well formed,
// some damaged, some pure noise.
// ----------------------------------------------------------------------------
module testbench;
  import cthv_pkg::*;

  localparam int unsigned CycleLimit = 500000;
  localparam string HdrName    = "Content-Type";
  localparam string Separators = "()<>@,;:\\\"/[]?={} \t";
  localparam logic [7:0] Specials [6] = '{ChSemi, ChEquals, ChQuote, ChSpace, ChNewline,
                                           ChSlash};

  typedef struct {
    logic [7:0] ch;
    logic       eol;
    bit         hold;
  } line_byte_t;

  typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] line_byte_i = 8'h00;
  logic       end_of_line_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       accepted_o;

  line_byte_t  pending_bytes[$];
  logic [7:0]  line_buf[$];
  logic        verdict_q[$];
  bit          any_fail = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned stall_tick = 0;
  stall_mode_e stall_mode = STALL_NONE;

  // grammar tracker state
  phase_e     gram_phase = PH_NAME;
  logic [3:0] name_pos = 4'd0;
  logic       seg_nonempty = 1'b0;
  logic       quoted_val = 1'b0;
  logic       quote_done = 1'b0;
  logic       line_bad = 1'b0;

  content_type_header_validator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .line_byte_i   (line_byte_i),
    .end_of_line_i (end_of_line_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .accepted_o    (accepted_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d verdicts outstanding", $time, verdict_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---- byte classes ----

  function automatic logic ctl_byte(logic [7:0] c);
    return (c < 8'd32) || (c == ChDel);
  endfunction

  function automatic logic blank_byte(logic [7:0] c);
    return (c == ChSpace) || (c == ChTab);
  endfunction

  function automatic logic tok_byte(logic [7:0] c);
    if (ctl_byte(c)) return 1'b0;
    for (int i = 0; i < Separators.len(); i++) begin
      if (c == Separators[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---- grammar tracker ----

  function automatic void clear_grammar();
    gram_phase   = PH_NAME;
    name_pos     = 4'd0;
    seg_nonempty = 1'b0;
    quoted_val   = 1'b0;
    quote_done   = 1'b0;
    line_bad     = 1'b0;
  endfunction

  function automatic void open_segment(phase_e p);
    gram_phase   = p;
    seg_nonempty = 1'b0;
    quoted_val   = 1'b0;
    quote_done   = 1'b0;
  endfunction

  function automatic void advance_grammar(logic [7:0] c);
    if (gram_phase == PH_LEAD) begin
      if (blank_byte(c)) return;
      gram_phase = PH_TYPE;
    end
    case (gram_phase)
      PH_NAME: begin
        if (name_pos < NameLen) begin
          if (c == HdrName[name_pos]) name_pos++;
          else line_bad = 1'b1;
        end else if (c == ChColon) open_segment(PH_LEAD);
        else line_bad = 1'b1;
      end
      PH_TYPE: begin
        if (tok_byte(c)) seg_nonempty = 1'b1;
        else if (c == ChSlash && seg_nonempty) open_segment(PH_SUB);
        else line_bad = 1'b1;
      end
      PH_SUB: begin
        if (tok_byte(c)) seg_nonempty = 1'b1;
        else if (c == ChSemi && seg_nonempty) open_segment(PH_KEY);
        else if (blank_byte(c) && seg_nonempty) gram_phase = PH_TRAIL;
        else line_bad = 1'b1;
      end
      PH_KEY: begin
        if (tok_byte(c)) seg_nonempty = 1'b1;
        else if (c == ChEquals && seg_nonempty) open_segment(PH_VALUE);
        else line_bad = 1'b1;
      end
      PH_VALUE: begin
        if (!seg_nonempty) begin
          if (c == ChQuote) begin
            quoted_val   = 1'b1;
            seg_nonempty = 1'b1;
          end else if (tok_byte(c)) seg_nonempty = 1'b1;
          else line_bad = 1'b1;
        end else if (quoted_val && !quote_done) begin
          if (c == ChQuote) quote_done = 1'b1;
          else if (c == ChSemi || (ctl_byte(c) && c != ChTab && c != ChNewline))
            line_bad = 1'b1;
        end else if (quoted_val) begin
          if (c == ChSemi) open_segment(PH_KEY);
          else if (blank_byte(c)) gram_phase = PH_TRAIL;
          else line_bad = 1'b1;
        end else begin
          if (tok_byte(c)) begin
          end else if (c == ChSemi) open_segment(PH_KEY);
          else if (blank_byte(c)) gram_phase = PH_TRAIL;
          else line_bad = 1'b1;
        end
      end
      PH_TRAIL: begin
        if (!blank_byte(c)) line_bad = 1'b1;
      end
      default: line_bad = 1'b1;
    endcase
  endfunction

  function automatic logic line_ok();
    if (line_bad) return 1'b0;
    case (gram_phase)
      PH_SUB:   return seg_nonempty;
      PH_VALUE: return seg_nonempty && (!quoted_val || quote_done);
      PH_TRAIL: return 1'b1;
      default:  return 1'b0;
    endcase
  endfunction

  function automatic void track_byte(logic [7:0] c, logic eol);
    if (!eol) begin
      if (!line_bad) advance_grammar(c);
    end else begin
      verdict_q.push_back((c == ChNewline) && line_ok());
      clear_grammar();
    end
  endfunction

  // ---- line building ----

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void commit_line(bit hold);
    for (int i = 0; i < line_buf.size(); i++) begin
      pending_bytes.push_back('{ch: line_buf[i], eol: (i == line_buf.size() - 1),
                                hold: (hold && i == 0)});
    end
    line_buf.delete();
  endfunction

  function automatic void directed_line(string s, bit hold);
    add_str(s);
    commit_line(hold);
  endfunction

  function automatic logic [7:0] rand_tok_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (!tok_byte(c));
    return c;
  endfunction

  function automatic void add_token(int unsigned max_len);
    repeat ($urandom_range(1, max_len)) line_buf.push_back(rand_tok_char());
  endfunction

  function automatic void add_blanks(int unsigned max_len);
    repeat ($urandom_range(0, max_len)) line_buf.push_back($urandom_range(0, 1) ? ChSpace : ChTab);
  endfunction

  function automatic void add_quoted();
    logic [7:0] c;
    line_buf.push_back(ChQuote);
    repeat ($urandom_range(0, 6)) begin
      do c = 8'($urandom_range(0, 255));
      while (c == ChQuote || c == ChSemi || (ctl_byte(c) && c != ChTab && c != ChNewline));
      line_buf.push_back(c);
    end
    line_buf.push_back(ChQuote);
  endfunction

  function automatic void add_wellformed();
    add_str(HdrName);
    line_buf.push_back(ChColon);
    add_blanks(2);
    add_token(5);
    line_buf.push_back(ChSlash);
    add_token(6);
    repeat ($urandom_range(0, 3)) begin
      line_buf.push_back(ChSemi);
      add_token(4);
      line_buf.push_back(ChEquals);
      if ($urandom_range(0, 1)) add_quoted();
      else add_token(6);
    end
    add_blanks(2);
    line_buf.push_back(ChNewline);
  endfunction

  function automatic void mangle_line();
    int unsigned pos;
    int unsigned roll;
    pos  = $urandom_range(0, line_buf.size() - 1);
    roll = $urandom_range(0, 99);
    if (roll < 30) line_buf[pos] = 8'($urandom_range(0, 255));
    else if (roll < 50) line_buf.insert(pos, 8'($urandom_range(0, 255)));
    else if (roll < 70 && line_buf.size() > 1) line_buf.delete(pos);
    else line_buf[pos] = Specials[$urandom_range(0, 5)];
  endfunction

  function automatic void build_directed();
    directed_line("Content-Type: text/html\n", 1'b0);
    directed_line("Content-Type:text/plain;charset=utf-8;q=1 \t\n", 1'b0);
    directed_line("Content-Type:\t a/b;k=\"x y\t\"\n", 1'b0);
    directed_line("Content-Type: a/b;k=\"\"  \n", 1'b0);
    directed_line("Content-Type: a/b;k=\"x\ny\"\n", 1'b0);
    directed_line("Content-Type: a/b;k=\"x\";q=v\n", 1'b1);
    directed_line("Content-Type: a/b;k=\"x\"y\n", 1'b0);
    directed_line("Content-Type: a/b;k=\"x;y\"\n", 1'b0);
    directed_line("Content-Type: a/b;k=\"abc\n", 1'b0);
    directed_line("Content-Type: a/b ;k=v\n", 1'b0);
    directed_line("Content-Type: a/b;k =v\n", 1'b0);
    directed_line("Content-Type: a/b; k=v\n", 1'b0);
    directed_line("Content-Type: a/b;\n", 1'b0);
    directed_line("Content-Type: a/b;k=\n", 1'b0);
    directed_line("Content-Type: a/\nb\n", 1'b0);
    directed_line("Content-Type: a/b", 1'b0);
    directed_line("content-type: a/b\n", 1'b0);
    directed_line("Content-Type a/b\n", 1'b0);
    directed_line("\n", 1'b0);
    line_buf.push_back(8'h00);
    commit_line(1'b0);
    add_str("Content-Type: ");
    line_buf.push_back(8'hFF);
    line_buf.push_back(ChSlash);
    line_buf.push_back(8'h80);
    line_buf.push_back(ChNewline);
    commit_line(1'b0);
    add_str("Content-Type: a/b");
    line_buf.push_back(ChDel);
    line_buf.push_back(ChNewline);
    commit_line(1'b0);
  endfunction

  function automatic void build_random();
    int unsigned lines;
    int unsigned roll;
    lines = 0;
    while (pending_bytes.size() < 500 || lines < 2) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        repeat ($urandom_range(1, 24)) line_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        add_wellformed();
        if (roll < 40) mangle_line();
        else if (roll < 46) void'(line_buf.pop_back());
      end
      commit_line($urandom_range(0, 29) == 0);
      lines++;
    end
  endfunction

  // ---- sender ----

  always @(posedge clk_i or negedge rst_ni) begin : byte_sender
    logic go;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      line_byte_i   <= 8'h00;
      end_of_line_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) track_byte(line_byte_i, end_of_line_i);
      if (!in_valid_i || !in_stall_o) begin
        go = 1'b0;
        if (pending_bytes.size() != 0) begin
          if (gap_left != 0) gap_left--;
          else if (!(pending_bytes[0].hold && verdict_q.size() != 0)) go = 1'b1;
        end
        if (go) begin
          in_valid_i    <= 1'b1;
          line_byte_i   <= pending_bytes[0].ch;
          end_of_line_i <= pending_bytes[0].eol;
          void'(pending_bytes.pop_front());
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---- receiver ----

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_tick == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_tick = $urandom_range(16, 80);
      end else begin
        stall_tick--;
      end
      case (stall_mode)
        STALL_NONE:     out_stall_i <= 1'b0;
        STALL_COIN:     out_stall_i <= ($urandom_range(0, 1) == 0);
        STALL_PERIODIC: out_stall_i <= (stall_tick % 5 < 2);
        default:        out_stall_i <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // ---- verdict check ----

  always @(posedge clk_i) begin : verdict_check
    logic want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, got %0b", $time, accepted_o);
        any_fail = 1'b1;
      end else begin
        want = verdict_q.pop_front();
        if (accepted_o !== want) begin
          $display("%0t: accepted_o mismatch, expected %0b, got %0b", $time, want, accepted_o);
          any_fail = 1'b1;
        end
      end
    end
  end

  initial begin
    build_directed();
    build_random();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_bytes.size() != 0 || in_valid_i || verdict_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (!any_fail) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
